### hdl/skt_pkg.sv
package skt_pkg;

   // operation codes
   localparam logic [1:0] FUNC_SEARCH = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_REMOVE = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_DONE   = 2'd0;
   localparam logic [1:0] STATUS_KEPT   = 2'd1;
   localparam logic [1:0] STATUS_ABSENT = 2'd2;
   localparam logic [1:0] STATUS_FULL   = 2'd3;

   localparam int KEY_WIDTH = 32;
   localparam int POS_WIDTH = 9;

   typedef struct packed {
      logic [1:0]                  func;
      logic signed [KEY_WIDTH-1:0] key;
      logic [15:0]                 payload;
      logic                        update;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [POS_WIDTH-1:0] position;
      logic [1:0]           status;
      logic [POS_WIDTH-1:0] entry_count;
   } rsp_type;

endpackage

### hdl/skt_ram.sv
module skt_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/skt_seq.sv
module skt_seq import skt_pkg::*; #(
   parameter int CAPACITY      = 256,
   parameter int PAYLOAD_WIDTH = 16,
   parameter int AW            = $clog2(CAPACITY),
   parameter int CW            = $clog2(CAPACITY + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   // command side
   input  logic                     start,
   input  req_type                  cmd,
   input  logic                     out_free,
   output logic                     done,
   output rsp_type                  result,
   // entry memory
   output logic                     mem_we,
   output logic [AW-1:0]            mem_waddr,
   output logic [KEY_WIDTH-1:0]     mem_wkey,
   output logic [PAYLOAD_WIDTH-1:0] mem_wpl,
   output logic                     mem_re,
   output logic [AW-1:0]            mem_raddr,
   input  logic [KEY_WIDTH-1:0]     mem_rkey,
   input  logic [PAYLOAD_WIDTH-1:0] mem_rpl
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SRCH, ST_CMP, ST_HIT, ST_ACT, ST_SHDN, ST_SHUP, ST_PUT_DONE
   } state_type;

   // ST_PUT_DONE is split by a flag to keep the enum compact
   state_type      state_ff, state_in;
   req_type        cmd_ff, cmd_in;
   logic [CW-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [CW-1:0]  pos_ff, pos_in, idx_ff, idx_in, cnt_ff, cnt_in;
   logic           hit_ff, hit_in;
   logic           put_ff, put_in;
   logic [1:0]     status_ff, status_in;

   logic [CW:0]    mid_sum;
   logic [CW-1:0]  mid;
   logic [CW:0]    pos_p1, idx_p2;
   logic [CW-1:0]  idx_m1, idx_m2, cnt_m1;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CW:1];
   assign pos_p1  = {1'b0, pos_ff} + (CW+1)'(1);
   assign idx_p2  = {1'b0, idx_ff} + (CW+1)'(2);
   assign idx_m1  = idx_ff - CW'(1);
   assign idx_m2  = idx_ff - CW'(2);
   assign cnt_m1  = cnt_ff - CW'(1);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      pos_in    = pos_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;
      hit_in    = hit_ff;
      put_in    = put_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      mem_waddr = pos_ff[AW-1:0];
      mem_wkey  = cmd_ff.key;
      mem_wpl   = PAYLOAD_WIDTH'(cmd_ff.payload);
      mem_re    = 1'b0;
      mem_raddr = mid[AW-1:0];
      done      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = cmd;
               lo_in    = '0;
               hi_in    = cnt_ff;
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               mem_re    = 1'b1;
               mem_raddr = mid[AW-1:0];
               mid_in    = mid;
               state_in  = ST_CMP;
            end else begin
               pos_in = lo_ff;
               if (lo_ff < cnt_ff) begin
                  mem_re    = 1'b1;
                  mem_raddr = lo_ff[AW-1:0];
                  state_in  = ST_HIT;
               end else begin
                  hit_in   = 1'b0;
                  state_in = ST_ACT;
               end
            end
         end
         ST_CMP: begin
            if ($signed(mem_rkey) < $signed(cmd_ff.key)) begin
               lo_in = mid_ff + CW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = ST_SRCH;
         end
         ST_HIT: begin
            hit_in   = (mem_rkey == cmd_ff.key);
            state_in = ST_ACT;
         end
         ST_ACT: begin
            state_in = ST_PUT_DONE;
            put_in   = 1'b0;
            case (cmd_ff.func)
               FUNC_INSERT: begin
                  if (hit_ff) begin
                     if (cmd_ff.update) begin
                        mem_we    = 1'b1;
                        status_in = STATUS_DONE;
                     end else begin
                        status_in = STATUS_KEPT;
                     end
                  end else if (cnt_ff >= CW'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     status_in = STATUS_DONE;
                     put_in    = 1'b1;
                     if (cnt_ff > pos_ff) begin
                        idx_in    = cnt_ff;
                        mem_re    = 1'b1;
                        mem_raddr = cnt_m1[AW-1:0];
                        state_in  = ST_SHDN;
                     end
                  end
               end
               FUNC_REMOVE: begin
                  if (hit_ff) begin
                     status_in = STATUS_DONE;
                     if (pos_p1 < {1'b0, cnt_ff}) begin
                        idx_in    = pos_ff;
                        mem_re    = 1'b1;
                        mem_raddr = pos_p1[AW-1:0];
                        state_in  = ST_SHUP;
                     end else begin
                        cnt_in = cnt_m1;
                     end
                  end else begin
                     status_in = STATUS_ABSENT;
                  end
               end
               default: begin
                  status_in = hit_ff ? STATUS_DONE : STATUS_ABSENT;
               end
            endcase
         end
         ST_SHDN: begin
            // move entry idx-1 to idx, next read already issued
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wkey  = mem_rkey;
            mem_wpl   = mem_rpl;
            idx_in    = idx_m1;
            if (idx_m1 > pos_ff) begin
               mem_re    = 1'b1;
               mem_raddr = idx_m2[AW-1:0];
            end else begin
               state_in = ST_PUT_DONE;
            end
         end
         ST_SHUP: begin
            // move entry idx+1 to idx
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wkey  = mem_rkey;
            mem_wpl   = mem_rpl;
            idx_in    = idx_ff + CW'(1);
            if (idx_p2 < {1'b0, cnt_ff}) begin
               mem_re    = 1'b1;
               mem_raddr = idx_p2[AW-1:0];
            end else begin
               cnt_in   = cnt_m1;
               state_in = ST_PUT_DONE;
            end
         end
         ST_PUT_DONE: begin
            if (put_ff) begin
               // place the new entry at the insertion point
               mem_we = 1'b1;
               cnt_in = cnt_ff + CW'(1);
               put_in = 1'b0;
            end else if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         put_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         put_ff   <= put_in;
      end
      cmd_ff    <= cmd_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
      status_ff <= status_in;
   end

   assign result.found       = hit_ff;
   assign result.position    = POS_WIDTH'(pos_ff);
   assign result.status      = status_ff;
   assign result.entry_count = POS_WIDTH'(cnt_ff);

endmodule

### hdl/sorted_key_table.sv
// Sorted key table: search, insert or remove one signed key per request.
// A request first runs a binary search over the entries; an insert of a new key then adds
// a placing step, and every entry moved (up to count on insert, count-1 on remove) is moved
// one at a time, as set by the single read port of the entry memory.
// Throughput: one request at a time; the next is taken as soon as its result has been loaded into
// the output register, so a response waiting there does not stall the next request's transfer.
module sorted_key_table import skt_pkg::*; #(
   parameter int CAPACITY      = 256,
   parameter int PAYLOAD_WIDTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Reset clears the entry count and the control state; memory contents are left as they are
   // (no clear pass).

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic    busy_ff, busy_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic    req_xfer;
   logic    out_free;
   logic    seq_done;
   rsp_type seq_result;

   // memory port wiring
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [KEY_WIDTH-1:0]     mem_wkey;
   logic [PAYLOAD_WIDTH-1:0] mem_wpl;
   logic                     mem_re;
   logic [AW-1:0]            mem_raddr;
   logic [KEY_WIDTH-1:0]     mem_rkey;
   logic [PAYLOAD_WIDTH-1:0] mem_rpl;

   // one request in flight; ready drops from transfer until its result is
   // handed to the output register
   assign req_ready = ~busy_ff;
   assign req_xfer  = req_valid & req_ready;

   // output slot free if empty or being emptied this cycle
   assign out_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (seq_done) begin
         busy_in      = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_in       = seq_result;
      end
      if (req_xfer) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   skt_seq #(
      .CAPACITY      (CAPACITY),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
      .AW            (AW),
      .CW            (CW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_xfer),
      .cmd       (req_data),
      .out_free  (out_free),
      .done      (seq_done),
      .result    (seq_result),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wkey  (mem_wkey),
      .mem_wpl   (mem_wpl),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rkey  (mem_rkey),
      .mem_rpl   (mem_rpl)
   );

   // keys, kept in ascending signed order below the entry count
   skt_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_WIDTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wkey),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rkey)
   );

   // payload handles, moved alongside their keys
   skt_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (PAYLOAD_WIDTH)
   ) u_pl_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wpl),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rpl)
   );

endmodule
